[rtl/core/sswt_pkg.sv]
// Package: shared types and field widths for the single-server queue wait tracker.
`timescale 1ns / 1ps
`default_nettype none

package sswt_pkg;

   localparam int ID_W    = 16;
   localparam int TICK_W  = 16;
   localparam int SVC_W   = 4;
   localparam int SUM_W   = 32;
   localparam int COUNT_W = 8;

   // One input beat: a tick, maybe with an arrival
   typedef struct packed {
      logic             arrival;
      logic [SVC_W-1:0] arrival_service_time;
   } req_type;

   // One result beat per tick
   typedef struct packed {
      logic               started;
      logic [ID_W-1:0]    started_id;
      logic [TICK_W-1:0]  wait_ticks;
      logic [SUM_W-1:0]   wait_accum;
      logic               server_busy;
      logic [ID_W-1:0]    serving_id;
      logic               dropped;
      logic [COUNT_W-1:0] queue_count;
   } rsp_type;

   // Waiting customer as stored in the ring
   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [TICK_W-1:0] arrived;
      logic [SVC_W-1:0]  service;
   } queue_entry_type;

   localparam int ENTRY_W = $bits(queue_entry_type);

   // Controller to datapath commands
   typedef struct packed {
      logic accept;   // input beat taken: enqueue phase
      logic read;     // head entry read issued
      logic exec;     // serve phase, result register loads
   } cmd_type;

endpackage

`default_nettype wire

[rtl/core/sswt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module sswt_ram #(
   parameter int WIDTH = 36,
   parameter int DEPTH = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[rtl/core/sswt_ctrl.sv]
// Controller: sequences each tick through accept, head read and serve phases.
`timescale 1ns / 1ps
`default_nettype none

module sswt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sswt_pkg::cmd_type     cmd
);

   import sswt_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_EXEC = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // Result register can take a new beat when empty or draining now
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.accept = (state_ff == ST_IDLE) && req_valid;
   assign cmd.read   = (state_ff == ST_READ);
   assign cmd.exec   = (state_ff == ST_EXEC) && out_free;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid flag
   always_comb begin
      if (cmd.exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/core/sswt_datapath.sv]
// Datapath: ring pointers, counters, server countdown, wait total and result register.
`timescale 1ns / 1ps
`default_nettype none

module sswt_datapath #(
   parameter int QUEUE_SLOTS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sswt_pkg::cmd_type cmd,
   input  wire sswt_pkg::req_type req_data,
   output sswt_pkg::rsp_type      rsp_data
);

   import sswt_pkg::*;

   localparam int IW = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

   logic [IW-1:0]      head_ff, head_in;
   logic [IW-1:0]      tail_ff, tail_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [ID_W-1:0]    next_id_ff, next_id_in;
   logic [SVC_W-1:0]   remain_ff, remain_in;
   logic [ID_W-1:0]    cur_id_ff, cur_id_in;
   logic [SUM_W-1:0]   wait_sum_ff, wait_sum_in;
   logic               dropped_ff, dropped_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;

   logic [IW-1:0]      tail_next;
   logic               full;
   logic               do_enq;
   queue_entry_type    wr_entry;
   queue_entry_type    rd_entry;
   logic [ENTRY_W-1:0] rd_raw;
   logic               start;
   logic               busy;
   logic [IW-1:0]      head_new;
   logic [TICK_W-1:0]  wait_w;
   logic [SUM_W:0]     sum_wide;
   logic [SUM_W-1:0]   sum_sat;
   logic [IW:0]        count_wide;
   logic [IW:0]        count_mod;

   function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] idx);
      logic [IW-1:0] res;
      if (idx == IW'(QUEUE_SLOTS - 1)) begin
         res = '0;
      end else begin
         res = idx + IW'(1);
      end
      return res;
   endfunction

   // Enqueue phase: entry goes to tail+1 unless the ring is full
   assign tail_next = ring_next(tail_ff);
   assign full      = (tail_next == head_ff);
   assign do_enq    = cmd.accept && req_data.arrival && !full;

   assign wr_entry.id      = next_id_ff;
   assign wr_entry.arrived = tick_ff;
   assign wr_entry.service = req_data.arrival_service_time;

   sswt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (QUEUE_SLOTS)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (do_enq),
      .wr_addr (tail_next),
      .wr_data (wr_entry),
      .rd_en   (cmd.read),
      .rd_addr (ring_next(head_ff)),
      .rd_data (rd_raw)
   );

   assign rd_entry = queue_entry_type'(rd_raw);

   // Serve phase: count down, or start the head customer
   assign busy     = (remain_ff != '0);
   assign start    = !busy && (head_ff != tail_ff);
   assign head_new = start ? ring_next(head_ff) : head_ff;
   assign wait_w   = tick_ff - rd_entry.arrived;
   assign sum_wide = {1'b0, wait_sum_ff} + {{(SUM_W + 1 - TICK_W){1'b0}}, wait_w};
   assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

   // Waiting count after the tick, modulo ring size
   assign count_wide = {1'b0, tail_ff} + (IW + 1)'(QUEUE_SLOTS) - {1'b0, head_new};
   assign count_mod  = (count_wide >= (IW + 1)'(QUEUE_SLOTS)) ?
                       count_wide - (IW + 1)'(QUEUE_SLOTS) : count_wide;

   // Next-state selection
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      tick_in     = tick_ff;
      next_id_in  = next_id_ff;
      remain_in   = remain_ff;
      cur_id_in   = cur_id_ff;
      wait_sum_in = wait_sum_ff;
      dropped_in  = dropped_ff;
      rsp_in      = rsp_ff;

      if (cmd.accept) begin
         dropped_in = req_data.arrival && full;
         if (do_enq) begin
            tail_in    = tail_next;
            next_id_in = next_id_ff + ID_W'(1);
         end
      end

      if (cmd.exec) begin
         tick_in = tick_ff + TICK_W'(1);
         head_in = head_new;
         if (busy) begin
            remain_in = remain_ff - SVC_W'(1);
         end else if (start) begin
            remain_in   = rd_entry.service;
            cur_id_in   = rd_entry.id;
            wait_sum_in = sum_sat;
         end

         rsp_in.started     = start;
         rsp_in.started_id  = start ? rd_entry.id : '0;
         rsp_in.wait_ticks  = start ? wait_w : '0;
         rsp_in.wait_accum  = start ? sum_sat : wait_sum_ff;
         rsp_in.server_busy = busy;
         rsp_in.serving_id  = start ? rd_entry.id : cur_id_ff;
         rsp_in.dropped     = dropped_ff;
         rsp_in.queue_count = COUNT_W'(count_mod[IW-1:0]);
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         tick_ff     <= '0;
         next_id_ff  <= '0;
         remain_ff   <= '0;
         cur_id_ff   <= '0;
         wait_sum_ff <= '0;
         dropped_ff  <= 1'b0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         tick_ff     <= tick_in;
         next_id_ff  <= next_id_in;
         remain_ff   <= remain_in;
         cur_id_ff   <= cur_id_in;
         wait_sum_ff <= wait_sum_in;
         dropped_ff  <= dropped_in;
      end
   end

   // Result payload register
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[rtl/core/single_server_queue_wait_tracker.sv]
// Top level: single-server queue wait tracker, controller plus datapath.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_valid / req_ready  sswt_pkg::req_type (one tick)
//   rsp_      out        rsp_valid / rsp_ready  sswt_pkg::rsp_type (one per tick)
//
// A tick runs through three phases: accept and enqueue, head read from the queue RAM (registered
// read port), then serve and load the result register. req_ready is high only while idle.
// Synchronous active-high reset clears pointers, counters and the wait total; the queue
// RAM is not cleared, as only written entries are ever dequeued.
// A stalled rsp_ready holds the serve phase until the result register frees up.
`timescale 1ns / 1ps
`default_nettype none

module single_server_queue_wait_tracker #(
   parameter int QUEUE_SLOTS = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire sswt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output sswt_pkg::rsp_type      rsp_data
);

   import sswt_pkg::*;

   cmd_type cmd;

   sswt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   sswt_datapath #(
      .QUEUE_SLOTS (QUEUE_SLOTS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

   // One tick in flight: no second beat right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second beat accepted while a tick is in flight");

   // A tick may count down or start a customer, never both
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.started && rsp_data.server_busy))
      else $error("start and countdown in the same tick");

   // Ring always leaves one slot free
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (32'(rsp_data.queue_count) < 32'(QUEUE_SLOTS)))
      else $error("queue count beyond ring capacity");

   // No start means no start id and no wait
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.started) |->
         (rsp_data.started_id == '0 && rsp_data.wait_ticks == '0))
      else $error("start fields set without a start");

endmodule

`default_nettype wire
